@@ rtl/core/gfta_pkg.sv @@
// shared types and constants for the fingertip track association block
package gfta_pkg;

  localparam int COORD_BITS = 10;
  localparam int MAX_CANDIDATES = 16;
  localparam int MAX_TRACKS = 32;
  localparam int TAG_BITS = 16;
  localparam int LIFE_BITS = 8;
  localparam int RANGE_BITS = 10;
  localparam int DIST_BITS = 2 * COORD_BITS + 1;

  localparam logic [RANGE_BITS-1:0] RANGE_RESET = 10'd75;
  localparam logic [LIFE_BITS-1:0] LIFETIME_RESET = 8'd10;
  localparam logic [TAG_BITS-1:0] NEW_AGE = 16'd1;

  localparam logic MODE_LOAD = 1'b0;
  localparam logic MODE_END = 1'b1;

  localparam logic REG_RANGE = 1'b0;
  localparam logic REG_LIFETIME = 1'b1;

  typedef struct packed {
    logic [COORD_BITS-1:0] tip_x;
    logic [COORD_BITS-1:0] tip_y;
    logic [COORD_BITS-1:0] base_x;
    logic [COORD_BITS-1:0] base_y;
  } pos_t;

  typedef struct packed {
    logic [TAG_BITS-1:0] age;
    logic [TAG_BITS-1:0] id;
  } tag_t;

  typedef struct packed {
    logic mode;
    pos_t pos;
  } req_t;

  typedef struct packed {
    logic valid;
    req_t req;
  } req_chan_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_MSCAN,
    S_MDEC,
    S_LEFT,
    S_LIFE,
    S_APP,
    S_EMIT
  } state_t;

endpackage

@@ rtl/core/gfta_front.sv @@
// request queue in front of the association engine
module gfta_front (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  input  gfta_pkg::req_t       req_in,
  output logic                 busy,
  output gfta_pkg::req_chan_t  head,
  input  logic                 pop
);

  gfta_pkg::req_t q_r [2];
  logic wp_r;
  logic rp_r;
  logic [1:0] cnt_r;
  logic push;

  assign busy = (cnt_r == 2'd2);
  assign push = start && !busy;
  assign head.valid = (cnt_r != 2'd0);
  assign head.req = q_r[rp_r];

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wp_r] <= req_in;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= 1'b0;
      rp_r <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) begin
        wp_r <= ~wp_r;
      end
      if (pop && head.valid) begin
        rp_r <= ~rp_r;
      end
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, pop && head.valid};
    end
  end

endmodule

@@ rtl/core/gfta_back.sv @@
// association engine: candidate store, track table, matching and result emission
module gfta_back #(
  parameter int MAX_CANDIDATES = gfta_pkg::MAX_CANDIDATES,
  parameter int MAX_TRACKS = gfta_pkg::MAX_TRACKS
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  gfta_pkg::req_chan_t               head,
  output logic                              pop,
  input  logic [gfta_pkg::RANGE_BITS-1:0]   match_range,
  input  logic [gfta_pkg::LIFE_BITS-1:0]    track_lifetime,
  output logic                              out_valid,
  output logic                              out_present,
  output gfta_pkg::pos_t                    out_pos,
  output gfta_pkg::tag_t                    out_tag,
  output logic                              out_last,
  output logic                              out_cand_ovf,
  output logic                              out_track_ovf
);

  localparam int CCW = $clog2(MAX_CANDIDATES + 1);
  localparam int CIW = (MAX_CANDIDATES > 1) ? $clog2(MAX_CANDIDATES) : 1;
  localparam int TCW = $clog2(MAX_TRACKS + 1);
  localparam int TIW = $clog2(MAX_TRACKS);
  localparam int DW = gfta_pkg::DIST_BITS;
  localparam int CBW = gfta_pkg::COORD_BITS;
  localparam logic [CCW-1:0] CMAX = CCW'(MAX_CANDIDATES);
  localparam logic [TCW-1:0] TMAX = TCW'(MAX_TRACKS);

  gfta_pkg::pos_t cand_pos_r [MAX_CANDIDATES];
  gfta_pkg::pos_t trk_pos_r [MAX_TRACKS];
  gfta_pkg::tag_t trk_tag_r [MAX_TRACKS];
  logic [gfta_pkg::LIFE_BITS-1:0] trk_life_r [MAX_TRACKS];
  gfta_pkg::pos_t tout_pos_r [MAX_CANDIDATES];
  gfta_pkg::tag_t tout_tag_r [MAX_CANDIDATES];

  gfta_pkg::state_t state_r, state_nxt;
  logic [CCW-1:0] ccnt_r;
  logic [CCW-1:0] c_r;
  logic [CCW-1:0] n_r;
  logic [CCW-1:0] k_r;
  logic [CCW-1:0] best_r;
  logic [TCW-1:0] tcnt_r;
  logic [TCW-1:0] m_r;
  logic [DW-1:0] best_d_r;
  logic [DW-1:0] limit_r;
  logic found_r;
  logic dropped_r;
  logic cand_ovf_r;
  logic track_ovf_r;
  logic [gfta_pkg::TAG_BITS-1:0] nid_r;

  gfta_pkg::pos_t tp, cp;
  logic [CBW-1:0] dx, dy;
  logic [DW-1:0] sq_dist;
  logic [TIW-1:0] mi, tlast;
  logic [CIW-1:0] clast;
  gfta_pkg::tag_t mtag;

  assign mi = m_r[TIW-1:0];
  assign tlast = TIW'(tcnt_r - TCW'(1));
  assign clast = CIW'(ccnt_r - CCW'(1));
  assign tp = trk_pos_r[mi];
  assign cp = cand_pos_r[c_r[CIW-1:0]];
  assign dx = (tp.tip_x > cp.tip_x) ? tp.tip_x - cp.tip_x : cp.tip_x - tp.tip_x;
  assign dy = (tp.tip_y > cp.tip_y) ? tp.tip_y - cp.tip_y : cp.tip_y - tp.tip_y;
  assign sq_dist = DW'(dx * dx) + DW'(dy * dy);
  assign mtag = trk_tag_r[mi];

  always_comb begin
    state_nxt = state_r;
    pop = 1'b0;
    case (state_r)
      gfta_pkg::S_IDLE: begin
        pop = head.valid;
        if (head.valid && head.req.mode == gfta_pkg::MODE_END) begin
          state_nxt = gfta_pkg::S_MSCAN;
        end
      end
      gfta_pkg::S_MSCAN: begin
        if (m_r >= tcnt_r) begin
          state_nxt = gfta_pkg::S_LEFT;
        end else if (c_r >= ccnt_r) begin
          state_nxt = gfta_pkg::S_MDEC;
        end
      end
      gfta_pkg::S_MDEC: state_nxt = gfta_pkg::S_MSCAN;
      gfta_pkg::S_LEFT: begin
        if (!(c_r < ccnt_r && n_r < CMAX)) begin
          state_nxt = gfta_pkg::S_LIFE;
        end
      end
      gfta_pkg::S_LIFE: begin
        if (m_r >= tcnt_r) begin
          state_nxt = gfta_pkg::S_APP;
        end
      end
      gfta_pkg::S_APP: begin
        if (k_r >= n_r) begin
          state_nxt = gfta_pkg::S_EMIT;
        end
      end
      gfta_pkg::S_EMIT: begin
        if (n_r == CCW'(0) || k_r + CCW'(1) >= n_r) begin
          state_nxt = gfta_pkg::S_IDLE;
        end
      end
      default: state_nxt = gfta_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= gfta_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    limit_r <= DW'(match_range * match_range);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ccnt_r <= '0;
      tcnt_r <= '0;
      dropped_r <= 1'b0;
      nid_r <= '0;
      out_valid <= 1'b0;
      c_r <= '0;
      m_r <= '0;
      n_r <= '0;
      k_r <= '0;
      found_r <= 1'b0;
      cand_ovf_r <= 1'b0;
      track_ovf_r <= 1'b0;
    end else begin
      out_valid <= 1'b0;
      case (state_r)
        gfta_pkg::S_IDLE: begin
          if (head.valid) begin
            if (head.req.mode == gfta_pkg::MODE_LOAD) begin
              if (ccnt_r < CMAX) begin
                cand_pos_r[ccnt_r[CIW-1:0]] <= head.req.pos;
                ccnt_r <= ccnt_r + CCW'(1);
              end else begin
                dropped_r <= 1'b1;
              end
            end else begin
              m_r <= '0;
              c_r <= '0;
              n_r <= '0;
              found_r <= 1'b0;
              best_d_r <= limit_r;
              track_ovf_r <= 1'b0;
            end
          end
        end
        gfta_pkg::S_MSCAN: begin
          if (m_r >= tcnt_r) begin
            c_r <= '0;
          end else if (c_r < ccnt_r) begin
            if (sq_dist < best_d_r) begin
              best_d_r <= sq_dist;
              best_r <= c_r;
              found_r <= 1'b1;
            end
            c_r <= c_r + CCW'(1);
          end
        end
        gfta_pkg::S_MDEC: begin
          if (found_r && n_r < CMAX) begin
            tout_pos_r[n_r[CIW-1:0]] <= cand_pos_r[best_r[CIW-1:0]];
            tout_tag_r[n_r[CIW-1:0]].id <= mtag.id;
            tout_tag_r[n_r[CIW-1:0]].age <= (mtag.age == '1) ? mtag.age : mtag.age + 1'b1;
            n_r <= n_r + CCW'(1);
            trk_pos_r[mi] <= trk_pos_r[tlast];
            trk_tag_r[mi] <= trk_tag_r[tlast];
            trk_life_r[mi] <= trk_life_r[tlast];
            tcnt_r <= tcnt_r - TCW'(1);
            cand_pos_r[best_r[CIW-1:0]] <= cand_pos_r[clast];
            ccnt_r <= ccnt_r - CCW'(1);
          end else begin
            m_r <= m_r + TCW'(1);
          end
          c_r <= '0;
          found_r <= 1'b0;
          best_d_r <= limit_r;
        end
        gfta_pkg::S_LEFT: begin
          if (c_r < ccnt_r && n_r < CMAX) begin
            tout_pos_r[n_r[CIW-1:0]] <= cp;
            tout_tag_r[n_r[CIW-1:0]].age <= gfta_pkg::NEW_AGE;
            tout_tag_r[n_r[CIW-1:0]].id <= nid_r;
            nid_r <= nid_r + 1'b1;
            n_r <= n_r + CCW'(1);
            c_r <= c_r + CCW'(1);
          end else begin
            ccnt_r <= '0;
            cand_ovf_r <= dropped_r;
            dropped_r <= 1'b0;
            m_r <= '0;
          end
        end
        gfta_pkg::S_LIFE: begin
          if (m_r < tcnt_r) begin
            if (trk_life_r[mi] <= 8'd1) begin
              trk_pos_r[mi] <= trk_pos_r[tlast];
              trk_tag_r[mi] <= trk_tag_r[tlast];
              trk_life_r[mi] <= trk_life_r[tlast];
              tcnt_r <= tcnt_r - TCW'(1);
            end else begin
              trk_life_r[mi] <= trk_life_r[mi] - 1'b1;
              m_r <= m_r + TCW'(1);
            end
          end else begin
            k_r <= '0;
          end
        end
        gfta_pkg::S_APP: begin
          if (k_r < n_r) begin
            if (tcnt_r < TMAX) begin
              trk_pos_r[tcnt_r[TIW-1:0]] <= tout_pos_r[k_r[CIW-1:0]];
              trk_tag_r[tcnt_r[TIW-1:0]] <= tout_tag_r[k_r[CIW-1:0]];
              trk_life_r[tcnt_r[TIW-1:0]] <= track_lifetime;
              tcnt_r <= tcnt_r + TCW'(1);
            end else begin
              track_ovf_r <= 1'b1;
            end
            k_r <= k_r + CCW'(1);
          end else begin
            k_r <= '0;
          end
        end
        gfta_pkg::S_EMIT: begin
          out_valid <= 1'b1;
          out_cand_ovf <= cand_ovf_r;
          out_track_ovf <= track_ovf_r;
          if (n_r == CCW'(0)) begin
            out_present <= 1'b0;
            out_pos <= '0;
            out_tag <= '0;
            out_last <= 1'b1;
          end else begin
            out_present <= 1'b1;
            out_pos <= tout_pos_r[k_r[CIW-1:0]];
            out_tag <= tout_tag_r[k_r[CIW-1:0]];
            out_last <= (k_r + CCW'(1) >= n_r);
            k_r <= k_r + CCW'(1);
          end
        end
        default: ;
      endcase
    end
  end

endmodule

@@ rtl/core/greedy_fingertip_track_association.sv @@
// top level of the greedy fingertip track association block
// A load request (mode 0) stores one candidate, or is dropped if the store is full; a
// two-deep request queue takes loads at one per cycle while the engine works, unless it is
// full. An end-of-frame request (mode 1) runs the match scan, which visits one candidate per
// cycle, then gives new ids to unmatched candidates, ages the tracks, appends the results to
// the track table and emits the results on consecutive cycles, one per out_valid strobe, the
// last with out_last set. An empty frame gives one result with out_present low. Results
// cannot be held off by the receiver. busy is high while the request queue is full.
module greedy_fingertip_track_association #(
  parameter int MAX_CANDIDATES = gfta_pkg::MAX_CANDIDATES,
  parameter int MAX_TRACKS = gfta_pkg::MAX_TRACKS
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic        in_mode,
  input  logic [9:0]  in_tip_x,
  input  logic [9:0]  in_tip_y,
  input  logic [9:0]  in_base_x,
  input  logic [9:0]  in_base_y,
  output logic        out_valid,
  output logic        out_present,
  output logic [9:0]  out_tip_x,
  output logic [9:0]  out_tip_y,
  output logic [9:0]  out_base_x,
  output logic [9:0]  out_base_y,
  output logic [15:0] out_age,
  output logic [15:0] out_finger_id,
  output logic        out_last,
  output logic        out_candidate_overflow,
  output logic        out_track_overflow,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [gfta_pkg::RANGE_BITS-1:0] range_r;
  logic [gfta_pkg::LIFE_BITS-1:0] life_r;
  gfta_pkg::req_t req_in;
  gfta_pkg::req_chan_t head;
  gfta_pkg::pos_t o_pos;
  gfta_pkg::tag_t o_tag;
  logic pop;
  logic wr_en;

  assign pready = 1'b1;
  assign wr_en = psel && penable && pwrite && pready;
  assign prdata = (paddr[2] == gfta_pkg::REG_LIFETIME) ? {24'd0, life_r} : {22'd0, range_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      range_r <= gfta_pkg::RANGE_RESET;
      life_r <= gfta_pkg::LIFETIME_RESET;
    end else if (wr_en) begin
      if (paddr[2] == gfta_pkg::REG_RANGE) begin
        range_r <= pwdata[9:0];
      end else begin
        life_r <= pwdata[7:0];
      end
    end
  end

  assign req_in.mode = in_mode;
  assign req_in.pos.tip_x = in_tip_x;
  assign req_in.pos.tip_y = in_tip_y;
  assign req_in.pos.base_x = in_base_x;
  assign req_in.pos.base_y = in_base_y;

  gfta_front u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .req_in (req_in),
    .busy   (busy),
    .head   (head),
    .pop    (pop)
  );

  gfta_back #(
    .MAX_CANDIDATES (MAX_CANDIDATES),
    .MAX_TRACKS     (MAX_TRACKS)
  ) u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .head           (head),
    .pop            (pop),
    .match_range    (range_r),
    .track_lifetime (life_r),
    .out_valid      (out_valid),
    .out_present    (out_present),
    .out_pos        (o_pos),
    .out_tag        (o_tag),
    .out_last       (out_last),
    .out_cand_ovf   (out_candidate_overflow),
    .out_track_ovf  (out_track_overflow)
  );

  assign out_tip_x = o_pos.tip_x;
  assign out_tip_y = o_pos.tip_y;
  assign out_base_x = o_pos.base_x;
  assign out_base_y = o_pos.base_y;
  assign out_age = o_tag.age;
  assign out_finger_id = o_tag.id;

  a_empty_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_present |-> out_last) else $error("empty frame result not last");

  a_gap_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_last |=> !out_valid) else $error("result after end of frame");

  a_present_age: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_present |-> out_age != 16'd0) else $error("fingertip with zero age");

endmodule
